>>> src/fss_pkg.sv
// Package for the fuzzy subsequence scorer: payload and scan-state types,
// register indexes, scoring constants and the case-fold function. No dependencies.
`timescale 1ns / 1ps

package fss_pkg;

  localparam int unsigned MaxQueryLen = 16;
  localparam int unsigned QidxW       = 5;
  localparam int unsigned PosW        = 5;
  localparam int unsigned MultW       = 11;
  localparam int unsigned ScoreW      = 18;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 64;

  localparam logic [PosW-1:0]           PosSaturate     = 5'd17;
  localparam logic signed [MultW-1:0]   MultReset       = 11'sd1;
  localparam logic signed [MultW-1:0]   BonusInPlace    = 11'sd50;
  localparam logic signed [MultW-1:0]   PenaltyOffPlace = 11'sd5;
  localparam logic signed [ScoreW-1:0]  StartScore      = 18'sd1000;
  localparam logic signed [ScoreW-1:0]  NoMatchScore    = -18'sd1;

  localparam logic [7:0] UpperA    = 8'h41;
  localparam logic [7:0] UpperZ    = 8'h5A;
  localparam logic [7:0] CaseDelta = 8'h20;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_QUERY_LOW  = 2'd0,
    CFG_QUERY_HIGH = 2'd1,
    CFG_QUERY_LEN  = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic [7:0] candidate_char;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic signed [ScoreW-1:0] match_score;
    logic                     matched;
  } out_t;

  typedef struct packed {
    logic [QidxW-1:0]         query_index;
    logic [PosW-1:0]          cand_pos;
    logic signed [MultW-1:0]  multiplier;
    logic signed [ScoreW-1:0] score;
  } scan_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= UpperA && c <= UpperZ) begin
      r = c + CaseDelta;
    end
    return r;
  endfunction

endpackage

>>> src/fuzzy_subsequence_scorer_top.sv
// Top level of the fuzzy subsequence scorer: config registers, scan state and
// output register. Depends on fss_pkg and fss_step.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in      | input     | in_valid_i/in_ready_o | in_data_i (char, last_char)
//  out     | output    | out_valid_o/out_ready_i | out_data_o (score, matched)
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  One byte per cycle; the scan state updates in the cycle the byte is taken.
//  A result appears in the output register the cycle after its last byte.
//  Input stalls only while the output register is full and not being taken.
//  Reset clears config to zero and the scan state to its start values.
`timescale 1ns / 1ps

module fuzzy_subsequence_scorer_top #(
  parameter int unsigned MAX_QUERY_LEN = fss_pkg::MaxQueryLen
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  fss_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output fss_pkg::out_t                   out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fss_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [fss_pkg::CfgDataW-1:0]    cfg_data_i
);

  localparam logic [fss_pkg::QidxW-1:0] MaxLen = fss_pkg::QidxW'(MAX_QUERY_LEN);

  logic [63:0]                  qlow_q, qhigh_q;
  logic [fss_pkg::QidxW-1:0]    qlen_q;
  logic [fss_pkg::QidxW-1:0]    qlen_eff;
  fss_pkg::scan_t               scan_q, scan_d, scan_rst;
  logic                         out_valid_q;
  fss_pkg::out_t                out_q;
  logic                         in_fire, out_fire;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_q && out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign qlen_eff    = (qlen_q > MaxLen) ? MaxLen : qlen_q;

  always_comb begin
    scan_rst.query_index = '0;
    scan_rst.cand_pos    = '0;
    scan_rst.multiplier  = fss_pkg::MultReset;
    scan_rst.score       = fss_pkg::StartScore;
  end

  fss_step u_step (
    .scan_i        (scan_q),
    .char_i        (in_data_i.candidate_char),
    .query_chars_i ({qhigh_q, qlow_q}),
    .qlen_i        (qlen_eff),
    .scan_o        (scan_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qlow_q  <= '0;
      qhigh_q <= '0;
      qlen_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fss_pkg::CFG_QUERY_LOW:  qlow_q  <= cfg_data_i;
        fss_pkg::CFG_QUERY_HIGH: qhigh_q <= cfg_data_i;
        fss_pkg::CFG_QUERY_LEN:  qlen_q  <= cfg_data_i[fss_pkg::QidxW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q      <= scan_rst;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        scan_q <= in_data_i.last_char ? scan_rst : scan_d;
      end
      if (in_fire && in_data_i.last_char) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_data_i.last_char) begin
      if (scan_d.query_index >= qlen_eff) begin
        out_q.match_score <= scan_d.score;
        out_q.matched     <= 1'b1;
      end else begin
        out_q.match_score <= fss_pkg::NoMatchScore;
        out_q.matched     <= 1'b0;
      end
    end
  end

  a_qidx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_q.query_index <= fss_pkg::QidxW'(MAX_QUERY_LEN))
    else $error("query index beyond query length limit");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_q.cand_pos <= fss_pkg::PosSaturate)
    else $error("candidate position beyond saturation");

  a_scan_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.last_char |=> scan_q.query_index == '0 && scan_q.cand_pos == '0)
    else $error("scan state not cleared after last byte");

  a_nomatch_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.matched |-> out_q.match_score == fss_pkg::NoMatchScore)
    else $error("unmatched result with a score");

  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.last_char |=> out_valid_q)
    else $error("last byte did not produce a result");

endmodule

>>> src/fss_step.sv
// One matching step: compares a candidate byte with the next query character and
// computes the next scan state. Depends on fss_pkg.
`timescale 1ns / 1ps

module fss_step (
  input  fss_pkg::scan_t                    scan_i,
  input  logic [7:0]                        char_i,
  input  logic [15:0][7:0]                  query_chars_i,
  input  logic [fss_pkg::QidxW-1:0]         qlen_i,
  output fss_pkg::scan_t                    scan_o
);

  logic [7:0]                        qc;
  logic                              hit;
  logic signed [fss_pkg::MultW-1:0]  mult_new;
  logic signed [fss_pkg::ScoreW-1:0] mult_ext;
  logic signed [fss_pkg::ScoreW-1:0] mult_x10;

  always_comb begin
    qc       = fss_pkg::fold_case(query_chars_i[scan_i.query_index[3:0]]);
    hit      = (scan_i.query_index < qlen_i) && (qc == fss_pkg::fold_case(char_i));
    mult_new = (scan_i.cand_pos == scan_i.query_index)
             ? scan_i.multiplier + fss_pkg::BonusInPlace
             : scan_i.multiplier - fss_pkg::PenaltyOffPlace;
    mult_ext = {{(fss_pkg::ScoreW-fss_pkg::MultW){mult_new[fss_pkg::MultW-1]}}, mult_new};
    // x10 as x8 + x2
    mult_x10 = (mult_ext <<< 3) + (mult_ext <<< 1);

    scan_o = scan_i;
    if (hit) begin
      scan_o.multiplier  = mult_new;
      scan_o.score       = scan_i.score + mult_x10;
      scan_o.query_index = scan_i.query_index + 1'b1;
    end
    if (scan_i.cand_pos < fss_pkg::PosSaturate) begin
      scan_o.cand_pos = scan_i.cand_pos + 1'b1;
    end
  end

endmodule

>>> bench/fuzzy_subsequence_scorer_top_tb.sv
// Testbench for fuzzy_subsequence_scorer_top: streams candidate strings, predicts each
// score in a small class and checks every result transaction against it.
// Depends on fss_pkg and the scorer RTL.
`timescale 1ns / 1ps

module fuzzy_subsequence_scorer_top_tb;

  localparam int ScoreScale  = 10;
  localparam int RandomChars = 1050;
  localparam int DrainCycles = 8;
  localparam logic [fss_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam logic [fss_pkg::CfgDataW-1:0] DirQueryLow  = 64'h7A5A_6040_7B5B_6241;
  localparam logic [fss_pkg::CfgDataW-1:0] DirQueryHigh = 64'h7F80_7E30_4D6D_FF00;

  class subseq_score_predictor;
    logic [fss_pkg::CfgDataW-1:0]      query_low;
    logic [fss_pkg::CfgDataW-1:0]      query_high;
    logic [fss_pkg::QidxW-1:0]         query_len;
    logic [fss_pkg::QidxW-1:0]         qidx;
    logic [fss_pkg::PosW-1:0]          pos;
    logic signed [fss_pkg::MultW-1:0]  mult;
    logic signed [fss_pkg::ScoreW-1:0] score;
    fss_pkg::out_t                     pending_scores[$];
    int                                score_errors;

    function new();
      query_low    = '0;
      query_high   = '0;
      query_len    = '0;
      score_errors = 0;
      restart();
    endfunction

    function void restart();
      qidx  = '0;
      pos   = '0;
      mult  = fss_pkg::MultReset;
      score = fss_pkg::StartScore;
    endfunction

    function logic [7:0] fold_letter(logic [7:0] c);
      if (c >= fss_pkg::UpperA && c <= fss_pkg::UpperZ) begin
        return c | fss_pkg::CaseDelta;
      end
      return c;
    endfunction

    function int unsigned active_len();
      return (query_len > fss_pkg::MaxQueryLen) ? fss_pkg::MaxQueryLen : query_len;
    endfunction

    function logic [7:0] query_byte(int unsigned i);
      logic [2*fss_pkg::CfgDataW-1:0] both;
      both = {query_high, query_low};
      return both[i*8 +: 8];
    endfunction

    function void write_reg(logic [fss_pkg::CfgIdxW-1:0] idx,
                            logic [fss_pkg::CfgDataW-1:0] data);
      case (idx)
        fss_pkg::CFG_QUERY_LOW:  query_low = data;
        fss_pkg::CFG_QUERY_HIGH: query_high = data;
        fss_pkg::CFG_QUERY_LEN:  query_len = data[fss_pkg::QidxW-1:0];
        default: ;
      endcase
    endfunction

    function void take_char(fss_pkg::in_t item);
      fss_pkg::out_t want;
      if (qidx < active_len() &&
          fold_letter(query_byte(qidx)) == fold_letter(item.candidate_char)) begin
        if (pos == qidx) begin
          mult = mult + fss_pkg::BonusInPlace;
        end else begin
          mult = mult - fss_pkg::PenaltyOffPlace;
        end
        score = score + fss_pkg::ScoreW'(int'(mult) * ScoreScale);
        qidx++;
      end
      if (pos < fss_pkg::PosSaturate) begin
        pos++;
      end
      if (item.last_char) begin
        if (qidx >= active_len()) begin
          want.match_score = score;
          want.matched     = 1'b1;
        end else begin
          want.match_score = fss_pkg::NoMatchScore;
          want.matched     = 1'b0;
        end
        pending_scores.insert(pending_scores.size(), want);
        restart();
      end
    endfunction

    function void check_score(fss_pkg::out_t got);
      fss_pkg::out_t want;
      if (pending_scores.size() == 0) begin
        $error("unexpected result: match_score %0d matched %0b", got.match_score, got.matched);
        score_errors++;
        return;
      end
      want = pending_scores.pop_front();
      if (got.match_score !== want.match_score) begin
        $error("match_score: expected %0d, actual %0d", want.match_score, got.match_score);
        score_errors++;
      end
      if (got.matched !== want.matched) begin
        $error("matched: expected %0b, actual %0b", want.matched, got.matched);
        score_errors++;
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  fss_pkg::in_t                 in_data;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  fss_pkg::out_t                out_data;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [fss_pkg::CfgIdxW-1:0]  cfg_index;
  logic [fss_pkg::CfgDataW-1:0] cfg_data;

  subseq_score_predictor model;
  int                    chars_sent;
  int                    burst_left;
  bit                    gaps_on;
  logic [15:0]           ready_pat = 16'hFFFF;
  int                    ready_hold = 0;

  fuzzy_subsequence_scorer_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk = ~clk;

  // receiver: rotating ready pattern, reloaded now and then; bit 0 forced so it never locks up
  always @(negedge clk) begin
    if (ready_hold == 0) begin
      ready_hold = $urandom_range(16, 160);
      case ($urandom_range(0, 3))
        0: ready_pat = '1;
        1: ready_pat = 16'($urandom) | 16'h1;
        2: ready_pat = 16'($urandom & $urandom) | 16'h1;
        default: ready_pat = 16'($urandom | $urandom) | 16'h1;
      endcase
    end
    out_ready = ready_pat[0];
    ready_pat = {ready_pat[0], ready_pat[15:1]};
    ready_hold--;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      model.check_score(out_data);
    end
  end

  function automatic logic [7:0] swap_case(logic [7:0] c);
    if ((c | fss_pkg::CaseDelta) >= (fss_pkg::UpperA | fss_pkg::CaseDelta) &&
        (c | fss_pkg::CaseDelta) <= (fss_pkg::UpperZ | fss_pkg::CaseDelta)) begin
      return c ^ fss_pkg::CaseDelta;
    end
    return c;
  endfunction

  function automatic logic [7:0] random_query_byte();
    if ($urandom_range(0, 1)) begin
      return 8'($urandom_range(0, 25)) +
             ($urandom_range(0, 1) ? fss_pkg::UpperA : (fss_pkg::UpperA | fss_pkg::CaseDelta));
    end
    return 8'($urandom);
  endfunction

  function automatic logic [fss_pkg::CfgDataW-1:0] random_query_word();
    logic [fss_pkg::CfgDataW-1:0] w;
    for (int i = 0; i < 8; i++) begin
      w[i*8 +: 8] = random_query_byte();
    end
    return w;
  endfunction

  task automatic send_char(logic [7:0] c, logic last);
    fss_pkg::in_t item;
    item.candidate_char = c;
    item.last_char      = last;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    in_valid = 1'b1;
    in_data  = item;
    do @(posedge clk); while (!in_ready);
    model.take_char(item);
    chars_sent++;
    burst_left--;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_candidate(input logic [7:0] bytes[$]);
    foreach (bytes[i]) begin
      send_char(bytes[i], i == bytes.size() - 1);
    end
  endtask

  task automatic write_cfg(logic [fss_pkg::CfgIdxW-1:0] idx,
                           logic [fss_pkg::CfgDataW-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    model.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (model.pending_scores.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // mostly the query in order with random case and noise; some with a dropped char, some noise only
  task automatic build_candidate(output logic [7:0] bytes[$]);
    int unsigned qlen;
    int unsigned kind;
    int unsigned skip;
    int unsigned noise_pct;
    logic [7:0]  q;
    bytes     = {};
    qlen      = model.active_len();
    kind      = $urandom_range(0, 9);
    noise_pct = (kind == 9) ? 60 : 20;
    skip      = (kind == 7 && qlen != 0) ? $urandom_range(0, qlen - 1) : qlen;
    if (kind == 8) begin
      repeat ($urandom_range(1, 24)) bytes.insert(bytes.size(), 8'($urandom));
    end else begin
      for (int i = 0; i < qlen; i++) begin
        while ($urandom_range(0, 99) < noise_pct) bytes.insert(bytes.size(), 8'($urandom));
        q = model.query_byte(i);
        if (i != skip) begin
          bytes.insert(bytes.size(), $urandom_range(0, 1) ? swap_case(q) : q);
        end
      end
      repeat ($urandom_range(0, (kind == 9) ? 12 : 3)) bytes.insert(bytes.size(), 8'($urandom));
    end
    if (bytes.size() == 0) begin
      bytes.insert(0, 8'($urandom));
    end
  endtask

  task automatic configure_phase(int phase);
    logic [fss_pkg::CfgDataW-1:0] low_word;
    logic [fss_pkg::CfgDataW-1:0] high_word;
    logic [fss_pkg::CfgDataW-1:0] len_word;
    int unsigned                  qlen;
    bit                           len_first;
    low_word  = random_query_word();
    high_word = random_query_word();
    case (phase)
      0: begin
        low_word  = '1;
        high_word = '1;
        qlen      = fss_pkg::MaxQueryLen;
      end
      1: begin
        low_word  = '0;
        high_word = '0;
        qlen      = 31;
      end
      2: qlen = 0;
      3: qlen = 1;
      default: qlen = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
    endcase
    len_word                      = {$urandom, $urandom};
    len_word[fss_pkg::QidxW-1:0]  = fss_pkg::QidxW'(qlen);
    len_first                     = $urandom_range(0, 1);
    if (len_first) begin
      write_cfg(fss_pkg::CFG_QUERY_LEN, len_word);
    end
    write_cfg(fss_pkg::CFG_QUERY_LOW, low_word);
    write_cfg(fss_pkg::CFG_QUERY_HIGH, high_word);
    if (!len_first) begin
      write_cfg(fss_pkg::CFG_QUERY_LEN, len_word);
    end
  endtask

  initial begin
    logic [7:0] cand[$];
    int         phase;
    int         phase_end;
    model      = new();
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = fss_pkg::CFG_QUERY_LOW;
    cfg_data   = '0;
    chars_sent = 0;
    burst_left = 0;
    gaps_on    = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty query after reset, and a write to the unused index
    write_cfg(CfgUnused, '1);
    send_char(8'h00, 1'b1);
    wait_idle();

    // '[' and '{' must not fold together
    write_cfg(fss_pkg::CFG_QUERY_LOW, DirQueryLow);
    write_cfg(fss_pkg::CFG_QUERY_HIGH, DirQueryHigh);
    write_cfg(fss_pkg::CFG_QUERY_LEN, 64'd3);
    send_char("a", 1'b0);
    send_char("B", 1'b0);
    send_char("{", 1'b1);
    // off-place matches, then a byte after the query is done
    send_char("x", 1'b0);
    send_char("A", 1'b0);
    send_char("b", 1'b0);
    send_char("[", 1'b0);
    send_char("A", 1'b1);
    wait_idle();

    // oversized length, full query in place with flipped case
    write_cfg(fss_pkg::CFG_QUERY_LEN, 64'd31);
    for (int i = 0; i < fss_pkg::MaxQueryLen; i++) begin
      send_char(swap_case(model.query_byte(i)), i == fss_pkg::MaxQueryLen - 1);
    end
    wait_idle();

    chars_sent = 0;
    phase      = 0;
    while (chars_sent < RandomChars) begin
      configure_phase(phase);
      gaps_on   = ($urandom_range(0, 3) != 0);
      phase_end = chars_sent + $urandom_range(60, 160);
      while (chars_sent < phase_end && chars_sent < RandomChars) begin
        build_candidate(cand);
        send_candidate(cand);
      end
      wait_idle();
      phase++;
    end

    if (model.score_errors == 0 && model.pending_scores.size() == 0) begin
      $display("fuzzy_subsequence_scorer_top_tb OK");
    end else begin
      $display("fuzzy_subsequence_scorer_top_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("fuzzy_subsequence_scorer_top_tb NOT OK");
    $finish;
  end

endmodule
